>>> rtl/sftenc_pkg.sv
// ----------------------------------------------------------------------------
// sftenc_pkg
// Shared types, constants and helpers for the serial-line CAN text encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sftenc_pkg;

  localparam int ID_W        = 29;
  localparam int LEN_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int NUM_BYTES   = 8;
  localparam int CHAR_W      = 7;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 8;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [ID_W-1:0]   STD_ID_MAX = 29'h7FF;
  localparam logic [LEN_W-1:0]  MAX_LEN    = 4'd8;
  localparam logic [CHAR_W-1:0] CHAR_STD   = 7'h74;  // 't'
  localparam logic [CHAR_W-1:0] CHAR_EXT   = 7'h54;  // 'T'
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_HEX_A = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;

  // one classified frame, as queued between front and back
  typedef struct packed {
    logic                             ext;
    logic [LEN_W-1:0]                 len;
    logic [ID_W-1:0]                  id;
    logic [NUM_BYTES-1:0][BYTE_W-1:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_ID,
    ST_LEN,
    ST_DATA,
    ST_EOL
  } gen_state_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] r;
    if (nib < 4'd10) begin
      r = CHAR_ZERO + {3'b000, nib};
    end else begin
      r = CHAR_HEX_A + {3'b000, nib - 4'd10};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/slcan_frame_text_encoder.sv
// ----------------------------------------------------------------------------
// slcan_frame_text_encoder
// Turns a CAN frame into its serial-line CAN ASCII text line, one character
// per output word.
//
//   channel | dir | tdata (low bit up)                               | tlast
//   s_      | in  | frame_id[28:0], frame_length[32:29],             | -
//           |     | data_byte_0..7 [96:33], zero fill [103:97]       |
//   m_      | out | text_char[6:0], zero fill [7]                    | end_of_line
//
// Each frame yields 6 + 2*len (standard) or 11 + 2*len (extended) words, at
// one word per cycle from the character generator when not stalled; frames
// follow each other with no gap. A frame is taken every cycle while the
// queue has room. Synchronous reset empties the queue and the output stage.
// A stall on the output holds the generator; the front keeps filling the queue meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_frame_text_encoder
  import sftenc_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // frame_id, frame_length, data_byte_0..7
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // text_char
  output logic                        m_tlast
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  sftenc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sftenc_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (q_cmd)
  );

  sftenc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/sftenc_front.sv
// ----------------------------------------------------------------------------
// sftenc_front
// Accepts frames, picks standard or extended form and clamps the length.
// ----------------------------------------------------------------------------
`default_nettype none

module sftenc_front
  import sftenc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output cmd_t                       push_cmd
);

  logic hold_valid;
  cmd_t hold_cmd;
  cmd_t cmd_in;
  logic accept;

  always_comb begin
    cmd_in.id   = s_tdata[ID_W-1:0];
    cmd_in.ext  = (s_tdata[ID_W-1:0] > STD_ID_MAX);
    cmd_in.len  = (s_tdata[ID_W +: LEN_W] > MAX_LEN) ? MAX_LEN : s_tdata[ID_W +: LEN_W];
    cmd_in.data = s_tdata[ID_W+LEN_W +: NUM_BYTES*BYTE_W];
  end

  assign s_tready   = !hold_valid || push_ready;
  assign accept     = s_tvalid && s_tready;
  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sftenc_fifo.sv
// ----------------------------------------------------------------------------
// sftenc_fifo
// Short frame queue between the front and the character generator.
// ----------------------------------------------------------------------------
`default_nettype none

module sftenc_fifo
  import sftenc_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire cmd_t wr_cmd,
  output logic      rd_valid,
  input  wire logic rd_pop,
  output cmd_t      rd_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_cmd   = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sftenc_back.sv
// ----------------------------------------------------------------------------
// sftenc_back
// Character generator: walks one queued frame and emits its text line,
// one character per word, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sftenc_back
  import sftenc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  input  wire cmd_t                   q_cmd,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast
);

  gen_state_t        state;
  gen_state_t        state_next;
  cmd_t              cmd;
  logic [3:0]        cnt;
  logic [3:0]        cnt_next;
  logic              step;
  logic              load;
  logic [CHAR_W-1:0] char_cur;
  logic              last_cur;
  logic [CHAR_W-1:0] out_char;
  logic              out_valid;
  logic              out_last;
  logic [31:0]       id_wide;
  logic [3:0]        id_nib;
  logic [BYTE_W-1:0] cur_byte;
  logic [3:0]        data_nib;
  logic              data_done;

  assign step = (state != ST_IDLE) && (!out_valid || m_tready);

  assign id_wide   = {3'b000, cmd.id};
  assign id_nib    = id_wide[{cnt[2:0], 2'b00} +: 4];
  assign cur_byte  = cmd.data[cnt[3:1]];
  assign data_nib  = cnt[0] ? cur_byte[3:0] : cur_byte[7:4];
  // last nibble of the payload is index 2*len-1
  assign data_done = ({1'b0, cnt} == ({cmd.len, 1'b0} - 5'd1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) state_next = ST_HEAD;
      end
      ST_HEAD: begin
        if (step) state_next = ST_ID;
      end
      ST_ID: begin
        if (step && cnt == 4'd0) state_next = ST_LEN;
      end
      ST_LEN: begin
        if (step) state_next = (cmd.len == '0) ? ST_EOL : ST_DATA;
      end
      ST_DATA: begin
        if (step && data_done) state_next = ST_EOL;
      end
      ST_EOL: begin
        if (step) state_next = q_valid ? ST_HEAD : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs, counter and queue pop
  always_comb begin
    char_cur = CHAR_CR;
    last_cur = 1'b0;
    cnt_next = cnt;
    load     = 1'b0;
    case (state)
      ST_IDLE: begin
        load = q_valid;
      end
      ST_HEAD: begin
        char_cur = cmd.ext ? CHAR_EXT : CHAR_STD;
        if (step) cnt_next = cmd.ext ? 4'd7 : 4'd2;
      end
      ST_ID: begin
        char_cur = hex_char(id_nib);
        if (step) cnt_next = cnt - 4'd1;
      end
      ST_LEN: begin
        char_cur = CHAR_ZERO + {3'b000, cmd.len};
        if (step) cnt_next = 4'd0;
      end
      ST_DATA: begin
        char_cur = hex_char(data_nib);
        if (step) cnt_next = cnt + 4'd1;
      end
      ST_EOL: begin
        char_cur = CHAR_CR;
        last_cur = 1'b1;
        load     = step && q_valid;
      end
      default: begin
        char_cur = CHAR_CR;
      end
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    if (load) begin
      cmd <= q_cmd;
    end
    if (step) begin
      out_char <= char_cur;
      out_last <= last_cur;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_char};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire
